// ===== rtl/core/bde_pkg.sv =====
// ----------------------------------------------------------------------------
// bde_pkg
// shared types, codes and word conversions for the bounded double-ended array
// ----------------------------------------------------------------------------
package bde_pkg;

  // capacity and stored word width
  localparam int unsigned DEPTH     = 64;
  localparam int unsigned WORD_BITS = 32;

  // derived widths
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // gather tree: cells per first-level group and number of groups
  localparam int unsigned GRP  = 8;
  localparam int unsigned NGRP = (DEPTH + GRP - 1) / GRP;

  // operation codes
  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_BACK   = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;

  // error codes
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;
  localparam logic [1:0] ERR_RANGE = 2'd3;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // input transaction
  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
    logic [5:0]         index;
  } in_t;

  // result transaction
  typedef struct packed {
    logic signed [31:0] read_word;
    logic signed [31:0] front_word;
    logic signed [31:0] back_word;
    logic [6:0]         count;
    logic               is_empty;
    logic               is_full;
    logic [1:0]         error_code;
  } out_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic wr_en;
    idx_t wr_idx;
  } cell_ctrl_t;

  // sign extend the input value and keep the stored width
  function automatic word_t to_word(logic signed [31:0] v);
    logic signed [63:0] ext;
    ext = 64'(v);
    return ext[WORD_BITS-1:0];
  endfunction

  // low 32 bits of a stored word, zero extended when narrower
  function automatic logic [31:0] to_out(word_t w);
    logic [63:0] ext;
    ext = 64'(w);
    return ext[31:0];
  endfunction

endpackage

// ===== rtl/core/bde_cell.sv =====
// ----------------------------------------------------------------------------
// bde_cell
// one storage slot of the shift array with its read and back taps
// ----------------------------------------------------------------------------
module bde_cell (
  input  logic                clk_i,
  input  bde_pkg::cell_ctrl_t ctrl_i,
  input  bde_pkg::idx_t       my_idx_i,
  input  bde_pkg::word_t      val_i,
  input  bde_pkg::word_t      lower_i,
  input  bde_pkg::word_t      upper_i,
  input  logic                rd_en_i,
  input  bde_pkg::idx_t       rd_idx_i,
  input  logic                bk_en_i,
  input  bde_pkg::idx_t       bk_idx_i,
  output bde_pkg::word_t      word_o,
  output bde_pkg::word_t      rd_word_o,
  output bde_pkg::word_t      bk_word_o
);
  import bde_pkg::*;

  word_t word_q;
  word_t word_d;

  // shift from a neighbor or load the pushed word
  always_comb begin
    word_d = word_q;
    if (ctrl_i.shift_up) begin
      word_d = lower_i;
    end else if (ctrl_i.shift_down) begin
      word_d = upper_i;
    end else if (ctrl_i.wr_en && (ctrl_i.wr_idx == my_idx_i)) begin
      word_d = val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  // taps gated by position match, merged by the gather tree
  assign word_o    = word_q;
  assign rd_word_o = (rd_en_i && (rd_idx_i == my_idx_i)) ? word_q : '0;
  assign bk_word_o = (bk_en_i && (bk_idx_i == my_idx_i)) ? word_q : '0;

endmodule

// ===== rtl/core/bde_gather.sv =====
// ----------------------------------------------------------------------------
// bde_gather
// two-level or tree that collects the read and back taps of all cells
// ----------------------------------------------------------------------------
module bde_gather (
  input  logic           clk_i,
  input  logic           load_i,
  input  bde_pkg::word_t rd_tap_i [bde_pkg::DEPTH],
  input  bde_pkg::word_t bk_tap_i [bde_pkg::DEPTH],
  output bde_pkg::word_t rd_word_o,
  output bde_pkg::word_t bk_word_o
);
  import bde_pkg::*;

  word_t rd_part_q [NGRP];
  word_t bk_part_q [NGRP];
  word_t rd_part_d [NGRP];
  word_t bk_part_d [NGRP];

  // first level: or of each group of cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      rd_part_d[g] = '0;
      bk_part_d[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < DEPTH) begin
          rd_part_d[g] = rd_part_d[g] | rd_tap_i[g*GRP+k];
          bk_part_d[g] = bk_part_d[g] | bk_tap_i[g*GRP+k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rd_part_q <= rd_part_d;
      bk_part_q <= bk_part_d;
    end
  end

  // second level: or of the registered group results
  always_comb begin
    rd_word_o = '0;
    bk_word_o = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_word_o = rd_word_o | rd_part_q[g];
      bk_word_o = bk_word_o | bk_part_q[g];
    end
  end

endmodule

// ===== rtl/core/bounded_double_ended_array.sv =====
// ----------------------------------------------------------------------------
// bounded_double_ended_array
// fixed-capacity deque of signed words built as a row of shifting cells
// ----------------------------------------------------------------------------
// channel  | direction | handshake               | payload
// in       | input     | in_valid_i / in_ready_o   | in_data_i  (bde_pkg::in_t)
// out      | output    | out_valid_o / out_ready_i | out_data_o (bde_pkg::out_t)
//
// a transaction runs in order: the cells update at the accepting edge, then
// state ST_GATH registers the first level of the read/back or tree, and state
// ST_DONE loads the result register. a new transaction is accepted while a
// result waits; if the result register is still full, ST_DONE holds until it
// is taken. reset clears the fill count; cell contents are not reset.
// ----------------------------------------------------------------------------
module bounded_double_ended_array (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bde_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bde_pkg::out_t out_data_o
);
  import bde_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_GATH = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  cnt_t       count_q, count_d;
  logic [1:0] err_q, err_d;
  logic       rd_en_q, rd_en_d;
  idx_t       rd_idx_q, rd_idx_d;
  logic       out_valid_q, out_valid_d;
  out_t       out_q;

  cell_ctrl_t ctrl;
  logic       accept;
  logic       full;
  logic       empty;
  logic       load_out;
  word_t      new_word;
  idx_t       bk_idx;
  word_t      cell_word [DEPTH];
  word_t      rd_tap    [DEPTH];
  word_t      bk_tap    [DEPTH];
  word_t      rd_word;
  word_t      bk_word;
  logic [CNT_W+5:0] index_ext;
  logic [CNT_W+5:0] count_ext;

  assign accept   = in_valid_i && in_ready_o;
  assign full     = (count_q == CNT_W'(DEPTH));
  assign empty    = (count_q == '0);
  assign new_word = to_word(in_data_i.value);
  assign index_ext = {{CNT_W{1'b0}}, in_data_i.index};
  assign count_ext = {6'b0, count_q};

  // decode the operation and work out cell control and the new count
  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    err_d    = err_q;
    rd_en_d  = rd_en_q;
    rd_idx_d = rd_idx_q;
    if (accept) begin
      err_d    = ERR_OK;
      rd_en_d  = 1'b0;
      rd_idx_d = IDX_W'(index_ext);
      case (in_data_i.op)
        OP_PUSH_BACK: begin
          if (full) begin
            err_d = ERR_FULL;
          end else begin
            ctrl.wr_en  = 1'b1;
            ctrl.wr_idx = IDX_W'(count_q);
            count_d     = count_q + 1'b1;
          end
        end
        OP_PUSH_FRONT: begin
          if (full) begin
            err_d = ERR_FULL;
          end else begin
            ctrl.shift_up = 1'b1;
            count_d       = count_q + 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            err_d = ERR_EMPTY;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            err_d = ERR_EMPTY;
          end else begin
            ctrl.shift_down = 1'b1;
            count_d         = count_q - 1'b1;
          end
        end
        OP_READ: begin
          if (index_ext >= count_ext) begin
            err_d = ERR_RANGE;
          end else begin
            rd_en_d = 1'b1;
          end
        end
        default: begin
          err_d = ERR_OK;
        end
      endcase
    end
  end

  assign bk_idx = IDX_W'(count_q - 1'b1);

  // row of cells, each handing its word to the neighbors
  for (genvar c = 0; c < DEPTH; c++) begin : g_cell
    bde_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .my_idx_i  (IDX_W'(c)),
      .val_i     (new_word),
      .lower_i   ((c == 0) ? new_word : cell_word[(c == 0) ? 0 : c-1]),
      .upper_i   ((c == DEPTH-1) ? cell_word[c] : cell_word[(c == DEPTH-1) ? c : c+1]),
      .rd_en_i   (rd_en_q),
      .rd_idx_i  (rd_idx_q),
      .bk_en_i   (!empty),
      .bk_idx_i  (bk_idx),
      .word_o    (cell_word[c]),
      .rd_word_o (rd_tap[c]),
      .bk_word_o (bk_tap[c])
    );
  end

  // collect the read and back words
  bde_gather u_gather (
    .clk_i     (clk_i),
    .load_i    (state_q == ST_GATH),
    .rd_tap_i  (rd_tap),
    .bk_tap_i  (bk_tap),
    .rd_word_o (rd_word),
    .bk_word_o (bk_word)
  );

  // sequencer
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_GATH;
        end
      end
      ST_GATH: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      err_q       <= ERR_OK;
      rd_en_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      rd_en_q     <= rd_en_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
  end

  // assemble the result transaction
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.read_word  <= to_out(rd_word);
      out_q.front_word <= empty ? '0 : to_out(cell_word[0]);
      out_q.back_word  <= to_out(bk_word);
      out_q.count      <= 7'(count_q);
      out_q.is_empty   <= empty;
      out_q.is_full    <= full;
      out_q.error_code <= err_q;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== verif/bounded_double_ended_array_test.sv =====
// ----------------------------------------------------------------------------
// bounded_double_ended_array_test
// drives push, pop, read and spare-code transactions into the bounded deque with random
// gaps on the input side and random stalls on the result side; a scoreboard
// keeps its own copy of the stored words and the fill level, predicts every
// result from the accepted transactions and checks each result field by field
// ----------------------------------------------------------------------------

// expected-state tracker: stored words, fill level and results still to come
class deque_tracker;
  bde_pkg::word_t slots[bde_pkg::DEPTH];
  int unsigned    fill;
  bde_pkg::out_t  pending_results[$];
  int unsigned    mismatch_count;

  function new();
    fill           = 0;
    mismatch_count = 0;
  endfunction

  // low 32 bits of a stored word, zero extended when the word is narrower
  function logic [31:0] visible_bits(bde_pkg::word_t w);
    logic [63:0] wide;
    wide = '0;
    wide[bde_pkg::WORD_BITS-1:0] = w;
    return wide[31:0];
  endfunction

  // apply one accepted transaction to the state and queue its result
  function void record_request(bde_pkg::in_t req);
    bde_pkg::out_t  res;
    bde_pkg::word_t w;
    logic [63:0]    wide;
    int unsigned    i;
    wide = {{32{req.value[31]}}, req.value};
    w    = wide[bde_pkg::WORD_BITS-1:0];
    res  = '0;
    case (req.op)
      bde_pkg::OP_PUSH_BACK: begin
        if (fill >= bde_pkg::DEPTH) begin
          res.error_code = bde_pkg::ERR_FULL;
        end else begin
          slots[fill] = w;
          fill++;
        end
      end
      bde_pkg::OP_PUSH_FRONT: begin
        if (fill >= bde_pkg::DEPTH) begin
          res.error_code = bde_pkg::ERR_FULL;
        end else begin
          for (i = fill; i > 0; i--) slots[i] = slots[i-1];
          slots[0] = w;
          fill++;
        end
      end
      bde_pkg::OP_POP_BACK: begin
        if (fill == 0) begin
          res.error_code = bde_pkg::ERR_EMPTY;
        end else begin
          fill--;
        end
      end
      bde_pkg::OP_POP_FRONT: begin
        if (fill == 0) begin
          res.error_code = bde_pkg::ERR_EMPTY;
        end else begin
          for (i = 0; i + 1 < fill; i++) slots[i] = slots[i+1];
          fill--;
        end
      end
      bde_pkg::OP_READ: begin
        if (req.index >= fill) begin
          res.error_code = bde_pkg::ERR_RANGE;
        end else begin
          res.read_word = visible_bits(slots[req.index]);
        end
      end
      default: begin
        // spare op codes leave everything as it is
      end
    endcase
    res.front_word = (fill != 0) ? visible_bits(slots[0]) : '0;
    res.back_word  = (fill != 0) ? visible_bits(slots[fill-1]) : '0;
    res.count      = 7'(fill);
    res.is_empty   = (fill == 0);
    res.is_full    = (fill == bde_pkg::DEPTH);
    pending_results.insert(pending_results.size(), res);
  endfunction

  function void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatch_count++;
    end
  endfunction

  // compare one accepted result with the oldest expectation
  function void compare_result(bde_pkg::out_t got);
    bde_pkg::out_t want;
    if (pending_results.size() == 0) begin
      $error("result with nothing pending: %p", got);
      mismatch_count++;
      return;
    end
    want = pending_results[0];
    pending_results.delete(0);
    check_field("read_word", want.read_word, got.read_word);
    check_field("front_word", want.front_word, got.front_word);
    check_field("back_word", want.back_word, got.back_word);
    check_field("count", 32'(want.count), 32'(got.count));
    check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
    check_field("is_full", 32'(want.is_full), 32'(got.is_full));
    check_field("error_code", 32'(want.error_code), 32'(got.error_code));
  endfunction
endclass

module bounded_double_ended_array_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bde_pkg::*;

  // spare op codes with no defined operation
  localparam logic [2:0] OP_SPARE_LO  = 3'd5;
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned IDLE_LIMIT   = 2000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  deque_tracker tracker = new();
  int unsigned  idle_cycles;
  int unsigned  level_seen;

  bounded_double_ended_array uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic in_t make_item(logic [2:0] op, logic [31:0] value, int unsigned index);
    in_t item;
    item.op    = op;
    item.value = value;
    item.index = 6'(index);
    return item;
  endfunction

  // fill level as the sender sees it, used to aim reads at stored words
  function automatic void track_level(in_t item);
    case (item.op)
      OP_PUSH_BACK, OP_PUSH_FRONT: if (level_seen < DEPTH) level_seen++;
      OP_POP_BACK, OP_POP_FRONT:   if (level_seen > 0) level_seen--;
      default: ;
    endcase
  endfunction

  // bias 0 drains, 1 balances, 2 fills
  function automatic in_t random_item(int unsigned bias);
    int unsigned roll;
    int unsigned push_pct;
    int unsigned pop_pct;
    logic [31:0] value;
    logic [2:0]  op;
    int unsigned index;
    push_pct = (bias == 2) ? 60 : (bias == 1) ? 35 : 15;
    pop_pct  = (bias == 2) ? 15 : (bias == 1) ? 30 : 55;
    roll     = $urandom_range(0, 99);
    if (roll < push_pct) begin
      op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    end else if (roll < push_pct + pop_pct) begin
      op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    end else if (roll < 96) begin
      op = OP_READ;
    end else begin
      op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end
    case ($urandom_range(0, 15))
      0:       value = 32'h7fff_ffff;
      1:       value = 32'h8000_0000;
      2:       value = 32'h0000_0000;
      3:       value = 32'hffff_ffff;
      default: value = $urandom;
    endcase
    if (level_seen > 0 && $urandom_range(0, 9) < 8) begin
      index = $urandom_range(0, level_seen - 1);
    end else begin
      index = $urandom_range(0, 63);
    end
    return make_item(op, value, index);
  endfunction

  // present one transaction, hold it until accepted, then idle for the requested gap
  task automatic send_item(in_t item, int unsigned gap);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    track_level(item);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold the input until every expected result has been taken
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // extremes of the fields, every op, the empty and range error cases and the spare codes
  task automatic run_directed();
    in_t plan[$];
    plan.insert(plan.size(), make_item(OP_POP_BACK, 32'h0, 0));
    plan.insert(plan.size(), make_item(OP_POP_FRONT, 32'hffff_ffff, 63));
    plan.insert(plan.size(), make_item(OP_READ, 32'h0, 0));
    plan.insert(plan.size(), make_item(OP_SPARE_LO, 32'hffff_ffff, 63));
    plan.insert(plan.size(), make_item(OP_SPARE_MID, 32'h8000_0000, 21));
    plan.insert(plan.size(), make_item(OP_SPARE_HI, 32'h7fff_ffff, 42));
    plan.insert(plan.size(), make_item(OP_PUSH_BACK, 32'h7fff_ffff, 0));
    plan.insert(plan.size(), make_item(OP_PUSH_FRONT, 32'h8000_0000, 63));
    plan.insert(plan.size(), make_item(OP_PUSH_BACK, 32'h0000_0000, 0));
    plan.insert(plan.size(), make_item(OP_PUSH_FRONT, 32'hffff_ffff, 0));
    plan.insert(plan.size(), make_item(OP_READ, 32'hffff_ffff, 0));
    plan.insert(plan.size(), make_item(OP_READ, 32'h0, 3));
    plan.insert(plan.size(), make_item(OP_READ, 32'h0, 4));
    plan.insert(plan.size(), make_item(OP_READ, 32'h0, 63));
    plan.insert(plan.size(), make_item(OP_SPARE_HI, 32'h1234_5678, 1));
    plan.insert(plan.size(), make_item(OP_POP_FRONT, 32'h0, 0));
    plan.insert(plan.size(), make_item(OP_POP_BACK, 32'h0, 0));
    plan.insert(plan.size(), make_item(OP_READ, 32'h0, 1));
    plan.insert(plan.size(), make_item(OP_READ, 32'h0, 2));
    plan.insert(plan.size(), make_item(OP_POP_FRONT, 32'h0, 0));
    plan.insert(plan.size(), make_item(OP_POP_BACK, 32'h0, 0));
    plan.insert(plan.size(), make_item(OP_POP_BACK, 32'h0, 0));
    plan.insert(plan.size(), make_item(OP_READ, 32'h0, 0));
    foreach (plan[k]) send_item(plan[k], pick_gap());
  endtask

  // phases that lean toward filling, balancing or draining the deque
  task automatic run_random(int unsigned total);
    int unsigned sent;
    int unsigned phase_left;
    int unsigned bias;
    bit          calm;
    sent       = 0;
    phase_left = 0;
    bias       = 2;
    calm       = 1'b0;
    while (sent < total) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(40, 160);
        bias       = $urandom_range(0, 2);
        calm       = ($urandom_range(0, 3) == 0);
      end
      send_item(random_item(bias), calm ? 0 : pick_gap());
      sent++;
      phase_left--;
      if (sent == total / 2) wait_drained();
    end
  endtask

  // result side: random stalls with occasional long stretches of ready
  initial begin
    int unsigned hold;
    int unsigned run;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 9) == 0) begin
        hold = 0;
        run  = $urandom_range(100, 300);
      end else begin
        hold = pick_gap();
        run  = $urandom_range(1, 20);
      end
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat (run) @(posedge clk_i);
    end
  end

  // transaction monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) tracker.record_request(in_data_i);
      if (out_valid_o && out_ready_i) tracker.compare_result(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    idle_cycles = 0;
    level_seen  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    wait_drained();
    run_random(RANDOM_ITEMS);
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (tracker.mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
